[sv/text_glyph_layout_top_defines.svh]
// ----------------------------------------------------------------------------
// Text glyph layout: assertion macros
// Shared property shapes for the layout checker.
// ----------------------------------------------------------------------------
`ifndef TEXT_GLYPH_LAYOUT_TOP_DEFINES_SVH
`define TEXT_GLYPH_LAYOUT_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define TGL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tgl: same-cycle property failed");

// Next-cycle implication, disabled while in reset
`define TGL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tgl: next-cycle property failed");

`endif

[sv/tgl_pkg.sv]
// ----------------------------------------------------------------------------
// Text glyph layout package
// Request types, record kind codes and layout constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tgl_pkg;

  // Record kinds
  localparam logic [2:0] KindAscii = 3'd0;
  localparam logic [2:0] KindHanzi = 3'd1;
  localparam logic [2:0] KindSkip  = 3'd2;
  localparam logic [2:0] KindEnd   = 3'd3;
  localparam logic [2:0] KindClip  = 3'd4;

  // Character code constants
  localparam logic [7:0] ByteTerm      = 8'h00;
  localparam logic [7:0] AsciiLimit    = 8'h7F;
  localparam logic [7:0] AsciiBase     = 8'h20;
  localparam logic [7:0] HanziBias     = 8'hA0;
  localparam int         HanziRowBias  = 16;
  localparam int         HanziRowPitch = 94;

  // Glyph widths in columns and page offsets
  localparam logic [7:0] AsciiWidth = 8'd8;
  localparam logic [7:0] HanziWidth = 8'd15;
  localparam logic [2:0] TopPageOfs = 3'd4;
  localparam logic [2:0] BotPageOfs = 3'd5;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       first_of_string;
    logic [6:0] start_column;
    logic [2:0] start_row;
    logic       invert_video;
  } tgl_in_t;

  typedef struct packed {
    logic [2:0]  record_kind;
    logic [11:0] glyph_index;
    logic [6:0]  display_column;
    logic [2:0]  top_page;
    logic [2:0]  bottom_page;
    logic        reverse_video;
  } tgl_out_t;

  // Cursor and string state carried between requests
  typedef struct packed {
    logic [7:0] cursor_column;
    logic [2:0] cursor_row;
    logic       invert_latched;
    logic [7:0] lead_byte;
    logic       lead_pending;
    logic       string_stopped;
  } tgl_state_t;

endpackage

[sv/text_glyph_layout_top.sv]
// ----------------------------------------------------------------------------
// Text glyph layout: top level
// Turns a mixed ASCII / GB2312 byte stream into glyph placement records.
// ----------------------------------------------------------------------------
// One string byte is taken every clock cycle while in_stall_o is low. Each
// byte is decoded combinationally against the cursor registers and any
// record it produces is registered in a two-entry output queue before it
// appears on the output. in_stall_o rises only when both queue entries hold
// records that the downstream side has not yet taken. A hanzi lead byte that
// fits and bytes outside a string produce no record.
`timescale 1ns / 1ps

module text_glyph_layout_top #(
  parameter int SCREEN_WIDTH = 128,
  parameter int ASCII_GLYPHS = 95,
  parameter int HANZI_GLYPHS = 3755
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tgl_pkg::tgl_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tgl_pkg::tgl_out_t out_data_o
);
  import tgl_pkg::*;

  // Idle until the first string start
  localparam tgl_state_t StateReset = '{
    cursor_column:  8'd0,
    cursor_row:     3'd0,
    invert_latched: 1'b0,
    lead_byte:      8'd0,
    lead_pending:   1'b0,
    string_stopped: 1'b1
  };

  tgl_state_t state_q, state_d;
  tgl_out_t   rec;
  logic       emit;
  logic       accept;
  logic       full;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  // Byte decode
  tgl_decode #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .ASCII_GLYPHS (ASCII_GLYPHS),
    .HANZI_GLYPHS (HANZI_GLYPHS)
  ) u_decode (
    .req_i   (in_data_i),
    .state_i (state_q),
    .state_o (state_d),
    .emit_o  (emit),
    .rec_o   (rec)
  );

  // Cursor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  // Record queue
  tgl_out_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept && emit),
    .push_data_i (rec),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[sv/tgl_decode.sv]
// ----------------------------------------------------------------------------
// Text glyph layout: character decode
// Classifies one string byte against the cursor state, forms the placement
// record and the next cursor state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tgl_decode #(
  parameter int SCREEN_WIDTH = 128,
  parameter int ASCII_GLYPHS = 95,
  parameter int HANZI_GLYPHS = 3755
) (
  input  tgl_pkg::tgl_in_t    req_i,
  input  tgl_pkg::tgl_state_t state_i,
  output tgl_pkg::tgl_state_t state_o,
  output logic                emit_o,
  output tgl_pkg::tgl_out_t   rec_o
);
  import tgl_pkg::*;

  localparam logic [8:0] AsciiClip = 9'(SCREEN_WIDTH - 8);
  localparam logic [8:0] HanziClip = 9'(SCREEN_WIDTH - 15);

  tgl_state_t         st;
  logic [7:0]         b;
  logic [7:0]         hi;
  logic [7:0]         lo;
  logic signed [9:0]  hi_off;
  logic signed [16:0] hz_idx;
  logic               hz_hit;
  logic [7:0]         asc_off;
  logic               asc_hit;
  logic [2:0]         kind;
  logic [11:0]        idx;

  assign b = req_i.text_byte;

  // Hanzi index from held lead byte and this trail byte (8-bit wrap)
  always_comb begin
    hi      = 8'(state_i.lead_byte - HanziBias);
    lo      = 8'(b - HanziBias);
    hi_off  = $signed({2'b00, hi}) - 10'(HanziRowBias);
    hz_idx  = 17'(hi_off) * 17'(HanziRowPitch) + 17'($signed({2'b00, lo})) - 17'sd1;
    hz_hit  = !hz_idx[16] && (hz_idx[15:0] < 16'(HANZI_GLYPHS));
    asc_off = 8'(b - AsciiBase);
    asc_hit = (b >= AsciiBase) && ({1'b0, asc_off} < 9'(ASCII_GLYPHS));
  end

  // Start-of-string load, then byte classification
  always_comb begin
    st = state_i;
    if (req_i.first_of_string) begin
      st.cursor_column  = {1'b0, req_i.start_column};
      st.cursor_row     = req_i.start_row;
      st.invert_latched = req_i.invert_video;
      st.lead_pending   = 1'b0;
      st.lead_byte      = '0;
      st.string_stopped = 1'b0;
    end
    state_o = st;
    emit_o  = 1'b0;
    kind    = KindSkip;
    idx     = '0;
    if (!st.string_stopped) begin
      priority if (st.lead_pending) begin
        state_o.lead_pending = 1'b0;
        emit_o = 1'b1;
        if (b == ByteTerm) begin
          state_o.string_stopped = 1'b1;
          kind = KindEnd;
        end else begin
          if (hz_hit) begin
            kind = KindHanzi;
            idx  = hz_idx[11:0];
          end
          state_o.cursor_column = st.cursor_column + HanziWidth;
        end
      end else if (b == ByteTerm) begin
        emit_o = 1'b1;
        state_o.string_stopped = 1'b1;
        kind = KindEnd;
      end else if (b < AsciiLimit) begin
        emit_o = 1'b1;
        if ({1'b0, st.cursor_column} > AsciiClip) begin
          state_o.string_stopped = 1'b1;
          kind = KindClip;
        end else begin
          if (asc_hit) begin
            kind = KindAscii;
            idx  = {4'b0000, asc_off};
          end
          state_o.cursor_column = st.cursor_column + AsciiWidth;
        end
      end else begin
        if ({1'b0, st.cursor_column} > HanziClip) begin
          emit_o = 1'b1;
          state_o.string_stopped = 1'b1;
          kind = KindClip;
        end else begin
          state_o.lead_byte    = b;
          state_o.lead_pending = 1'b1;
        end
      end
    end
  end

  // Record fields from the cursor as it stands before advancing
  always_comb begin
    rec_o.record_kind    = kind;
    rec_o.glyph_index    = idx;
    rec_o.display_column = (st.cursor_column[6:0] == 7'd0) ? 7'd1 : st.cursor_column[6:0];
    rec_o.top_page       = st.cursor_row + TopPageOfs;
    rec_o.bottom_page    = st.cursor_row + BotPageOfs;
    rec_o.reverse_video  = st.invert_latched;
  end

endmodule

[sv/tgl_out_queue.sv]
// ----------------------------------------------------------------------------
// Text glyph layout: result queue
// Two-entry register queue that holds placement records while the
// downstream side stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tgl_out_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tgl_pkg::tgl_out_t push_data_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tgl_pkg::tgl_out_t out_data_o
);
  import tgl_pkg::*;

  tgl_out_t   mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign pop         = (count_q != 2'd0) && !out_stall_i;
  assign out_valid_o = (count_q != 2'd0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign full_o      = (count_q == 2'd2);

  // Pointer and fill count
  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Record storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[sv/tgl_checker.sv]
// ----------------------------------------------------------------------------
// Text glyph layout: port checker
// Watches the output channel of the top level and checks record form.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "text_glyph_layout_top_defines.svh"

module tgl_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_stall_i,
  input tgl_pkg::tgl_out_t out_data_i
);
  import tgl_pkg::*;

  logic held;
  logic no_glyph;

  assign held     = out_valid_i && out_stall_i;
  assign no_glyph = (out_data_i.record_kind == KindSkip) ||
                    (out_data_i.record_kind == KindEnd) ||
                    (out_data_i.record_kind == KindClip);

  // Stalled record stays put
  `TGL_ASSERT_NEXT(a_hold_valid, clk_i, rst_ni, held, out_valid_i)
  `TGL_ASSERT_NEXT(a_hold_data, clk_i, rst_ni, held, $stable(out_data_i))
  // Panel column zero is never sent
  `TGL_ASSERT_NOW(a_col_nonzero, clk_i, rst_ni, out_valid_i, out_data_i.display_column != 7'd0)
  // Bottom page sits one below the top page
  `TGL_ASSERT_NOW(a_page_pair, clk_i, rst_ni, out_valid_i, out_data_i.bottom_page == 3'(out_data_i.top_page + 3'd1))
  // Records without a glyph carry index zero
  `TGL_ASSERT_NOW(a_idx_zero, clk_i, rst_ni, out_valid_i && no_glyph, out_data_i.glyph_index == 12'd0)

endmodule

bind text_glyph_layout_top tgl_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// Text glyph layout: testbench
// Feeds string bytes into the layout block with random gaps on both sides.
// Each placement record is checked against an independent cursor model.
// ----------------------------------------------------------------------------
// A directed run covers the glyph range edges, clipping, restart and the
// zero trail byte. Random strings with mostly well-formed content follow,
// plus some noise. A watchdog ends the run if nothing moves for too long.
`timescale 1ns / 1ps

module testbench;
  import tgl_pkg::*;

  localparam int SCREEN_WIDTH = 128;
  localparam int ASCII_GLYPHS = 95;
  localparam int HANZI_GLYPHS = 3755;
  localparam int RANDOM_ITEMS = 650;
  localparam int CALM_TAIL    = 60;
  localparam int STALL_LIMIT  = 1000;

  typedef struct {
    tgl_in_t req;
    bit      drain_first;
  } backlog_entry_t;

  logic     clk_i     = 1'b0;
  logic     rst_ni    = 1'b0;
  logic     in_valid  = 1'b0;
  tgl_in_t  in_data   = '0;
  logic     out_stall = 1'b0;
  logic     in_stall_o;
  logic     out_valid_o;
  tgl_out_t out_data_o;

  backlog_entry_t byte_backlog[$];
  tgl_out_t       placements_due[$];
  tgl_state_t     cursor;
  bit             drain_next = 1'b0;
  bit             drained    = 1'b1;
  bit             calm       = 1'b0;
  int             mismatches = 0;

  text_glyph_layout_top #(
    .SCREEN_WIDTH(SCREEN_WIDTH),
    .ASCII_GLYPHS(ASCII_GLYPHS),
    .HANZI_GLYPHS(HANZI_GLYPHS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Record at the current cursor; column 0 goes out as 1
  function automatic tgl_out_t cursor_record(input logic [2:0] kind, input logic [11:0] index);
    tgl_out_t rec;
    rec.record_kind    = kind;
    rec.glyph_index    = index;
    rec.display_column = cursor.cursor_column[6:0];
    if (rec.display_column == 7'd0) rec.display_column = 7'd1;
    rec.top_page      = cursor.cursor_row + TopPageOfs;
    rec.bottom_page   = cursor.cursor_row + BotPageOfs;
    rec.reverse_video = cursor.invert_latched;
    return rec;
  endfunction

  // Advance the cursor model by one accepted byte; returns 1 if a record is due
  function automatic bit place_glyph(input tgl_in_t req, output tgl_out_t rec);
    logic [7:0] code;
    logic [7:0] hi_ofs;
    logic [7:0] lo_ofs;
    int         idx;
    code = req.text_byte;
    rec  = '0;
    if (req.first_of_string) begin
      cursor.cursor_column  = {1'b0, req.start_column};
      cursor.cursor_row     = req.start_row;
      cursor.invert_latched = req.invert_video;
      cursor.lead_pending   = 1'b0;
      cursor.lead_byte      = 8'd0;
      cursor.string_stopped = 1'b0;
    end
    if (cursor.string_stopped) return 1'b0;

    // Trail byte of a hanzi
    if (cursor.lead_pending) begin
      cursor.lead_pending = 1'b0;
      if (code == ByteTerm) begin
        cursor.string_stopped = 1'b1;
        rec = cursor_record(KindEnd, 12'd0);
        return 1'b1;
      end
      hi_ofs = cursor.lead_byte - HanziBias;
      lo_ofs = code - HanziBias;
      idx = (int'(hi_ofs) - HanziRowBias) * HanziRowPitch + (int'(lo_ofs) - 1);
      if (idx >= 0 && idx < HANZI_GLYPHS) rec = cursor_record(KindHanzi, idx[11:0]);
      else rec = cursor_record(KindSkip, 12'd0);
      cursor.cursor_column = cursor.cursor_column + HanziWidth;
      return 1'b1;
    end

    if (code == ByteTerm) begin
      cursor.string_stopped = 1'b1;
      rec = cursor_record(KindEnd, 12'd0);
      return 1'b1;
    end

    // Narrow glyph
    if (code < AsciiLimit) begin
      if (int'(cursor.cursor_column) > SCREEN_WIDTH - int'(AsciiWidth)) begin
        cursor.string_stopped = 1'b1;
        rec = cursor_record(KindClip, 12'd0);
        return 1'b1;
      end
      if (code >= AsciiBase && int'(code) - int'(AsciiBase) < ASCII_GLYPHS)
        rec = cursor_record(KindAscii, {4'd0, code - AsciiBase});
      else
        rec = cursor_record(KindSkip, 12'd0);
      cursor.cursor_column = cursor.cursor_column + AsciiWidth;
      return 1'b1;
    end

    // Lead byte: held unless the wide glyph would not fit
    if (int'(cursor.cursor_column) > SCREEN_WIDTH - int'(HanziWidth)) begin
      cursor.string_stopped = 1'b1;
      rec = cursor_record(KindClip, 12'd0);
      return 1'b1;
    end
    cursor.lead_byte    = code;
    cursor.lead_pending = 1'b1;
    return 1'b0;
  endfunction

  task automatic queue_byte(input logic [7:0] b, input logic first, input logic [6:0] col,
                            input logic [2:0] row, input logic inv);
    backlog_entry_t e;
    e.req.text_byte       = b;
    e.req.first_of_string = first;
    e.req.start_column    = col;
    e.req.start_row       = row;
    e.req.invert_video    = inv;
    e.drain_first         = drain_next;
    drain_next            = 1'b0;
    byte_backlog.push_back(e);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Request driver: presents the backlog head, random gaps between requests
  always @(posedge clk_i) begin : driver
    bit busy;
    int send_gap;
    int send_odds;
    busy = in_valid;
    if (rst_ni) begin
      if (in_valid && !in_stall_o) begin
        void'(byte_backlog.pop_front());
        busy = 1'b0;
        if ($urandom_range(63) == 0) begin
          case ($urandom_range(2))
            0: send_odds = 0;
            1: send_odds = 3;
            default: send_odds = 8;
          endcase
        end
        if (!calm && $urandom_range(15) < send_odds) send_gap = $urandom_range(19, 1);
        // Let the drained flag settle before a drain point
        if (byte_backlog.size() > 0 && byte_backlog[0].drain_first && send_gap < 2)
          send_gap = 2;
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (byte_backlog.size() > 0 && (!byte_backlog[0].drain_first || drained)) begin
          in_valid <= 1'b1;
          in_data  <= byte_backlog[0].req;
        end else begin
          in_valid <= 1'b0;
        end
      end
      calm <= (byte_backlog.size() < CALM_TAIL);
    end
  end

  // Record monitor: checks records, predicts from accepted requests
  always @(posedge clk_i) begin : monitor
    tgl_out_t due;
    tgl_out_t rec;
    bit       has_rec;
    int       stall_left;
    int       recv_odds;
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        if (placements_due.size() == 0) begin
          mismatches++;
          $display("%0t: record not due, expected none, actual %p", $time, out_data_o);
        end else begin
          due = placements_due.pop_front();
          check_field("record_kind", due.record_kind, out_data_o.record_kind);
          check_field("glyph_index", due.glyph_index, out_data_o.glyph_index);
          check_field("display_column", due.display_column, out_data_o.display_column);
          check_field("top_page", due.top_page, out_data_o.top_page);
          check_field("bottom_page", due.bottom_page, out_data_o.bottom_page);
          check_field("reverse_video", due.reverse_video, out_data_o.reverse_video);
        end
      end
      // A record never leaves in the cycle its byte goes in
      if (in_valid && !in_stall_o) begin
        has_rec = place_glyph(in_data, rec);
        if (has_rec) placements_due.push_back(rec);
      end
      drained <= (placements_due.size() == 0);

      // Downstream stall bursts
      if ($urandom_range(63) == 0) begin
        case ($urandom_range(2))
          0: recv_odds = 0;
          1: recv_odds = 2;
          default: recv_odds = 6;
        endcase
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(15) < recv_odds) begin
        stall_left = $urandom_range(19, 1) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on handshake progress
  always @(posedge clk_i) begin : watchdog
    int quiet;
    if (rst_ni) begin
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // Stimulus and end of run
  initial begin : stimulus
    logic [7:0] str_bytes[$];
    int         n_rand;
    int         len;
    int         pick;
    logic [6:0] col;
    logic [2:0] row;
    logic       inv;

    cursor = '0;
    cursor.string_stopped = 1'b1;

    // Directed: byte before any string start is ignored
    queue_byte(8'h41, 1'b0, 7'd0, 3'd0, 1'b0);
    // Glyph range edges, row wrap of pages, reverse video
    queue_byte(8'h41, 1'b1, 7'd0, 3'd7, 1'b1);
    queue_byte(8'h20, 1'b0, 7'd127, 3'd7, 1'b1);
    queue_byte(8'h7E, 1'b0, 7'd0, 3'd0, 1'b0);
    queue_byte(8'h1F, 1'b0, 7'd0, 3'd0, 1'b0);
    queue_byte(8'hB0, 1'b0, 7'd0, 3'd0, 1'b0);
    queue_byte(8'hA1, 1'b0, 7'd0, 3'd0, 1'b0);
    queue_byte(8'hD7, 1'b0, 7'd0, 3'd0, 1'b0);
    queue_byte(8'hF9, 1'b0, 7'd0, 3'd0, 1'b0);
    queue_byte(8'hD7, 1'b0, 7'd0, 3'd0, 1'b0);
    queue_byte(8'hFA, 1'b0, 7'd0, 3'd0, 1'b0);
    // Index wrap on the lead byte
    queue_byte(8'h7F, 1'b0, 7'd0, 3'd0, 1'b0);
    queue_byte(8'hFF, 1'b0, 7'd0, 3'd0, 1'b0);
    // Restart while a lead byte is held, then clip at column 128
    queue_byte(8'hB0, 1'b0, 7'd0, 3'd0, 1'b0);
    queue_byte(8'hB0, 1'b1, 7'd113, 3'd3, 1'b0);
    queue_byte(8'hA1, 1'b0, 7'd0, 3'd0, 1'b0);
    queue_byte(8'h41, 1'b0, 7'd0, 3'd0, 1'b0);
    queue_byte(8'h58, 1'b0, 7'd0, 3'd0, 1'b0);
    // Last narrow column, then terminator
    queue_byte(8'h41, 1'b1, 7'd120, 3'd0, 1'b0);
    queue_byte(8'h00, 1'b0, 7'd0, 3'd0, 1'b0);
    // Clip on narrow and wide glyphs
    queue_byte(8'h41, 1'b1, 7'd121, 3'd1, 1'b1);
    queue_byte(8'hC0, 1'b1, 7'd114, 3'd2, 1'b0);
    // Empty string at the last column
    queue_byte(8'h00, 1'b1, 7'd127, 3'd5, 1'b1);
    // Zero trail byte
    queue_byte(8'h80, 1'b1, 7'd5, 3'd6, 1'b0);
    queue_byte(8'h00, 1'b0, 7'd0, 3'd0, 1'b0);

    // Random strings, with drain points at the start and near the middle
    drain_next = 1'b1;
    n_rand = 0;
    while (n_rand < RANDOM_ITEMS - 25) begin
      if (n_rand > RANDOM_ITEMS / 2 && n_rand < RANDOM_ITEMS / 2 + 15) drain_next = 1'b1;
      pick = $urandom_range(9);
      if (pick == 0) begin
        queue_byte(8'($urandom_range(255)), $urandom_range(3) == 0, 7'($urandom_range(127)),
                   3'($urandom_range(7)), 1'($urandom_range(1)));
        n_rand++;
      end else begin
        str_bytes.delete();
        len = $urandom_range(12, 0);
        repeat (len) begin
          pick = $urandom_range(19);
          if (pick < 10) begin
            str_bytes.push_back(8'($urandom_range(8'h7E, 8'h20)));
          end else if (pick == 10) begin
            str_bytes.push_back(8'($urandom_range(8'h1F, 8'h01)));
          end else if (pick < 18) begin
            str_bytes.push_back(8'($urandom_range(8'hF7, 8'hB0)));
            str_bytes.push_back(8'($urandom_range(8'hFE, 8'hA1)));
          end else begin
            str_bytes.push_back(8'($urandom_range(8'hFF, 8'h7F)));
            str_bytes.push_back(8'($urandom_range(8'hFF, 8'h01)));
          end
        end
        pick = $urandom_range(9);
        if (pick < 8) begin
          str_bytes.push_back(8'h00);
        end else if (pick == 8) begin
          str_bytes.push_back(8'($urandom_range(8'hF7, 8'hB0)));
          str_bytes.push_back(8'h00);
        end
        if (str_bytes.size() == 0) str_bytes.push_back(8'h00);
        col = ($urandom_range(3) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(24));
        row = 3'($urandom_range(7));
        inv = 1'($urandom_range(1));
        foreach (str_bytes[k]) begin
          if (k == 0) queue_byte(str_bytes[k], 1'b1, col, row, inv);
          else queue_byte(str_bytes[k], 1'b0, 7'($urandom_range(127)), 3'($urandom_range(7)),
                          1'($urandom_range(1)));
          n_rand++;
        end
      end
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (byte_backlog.size() != 0 || placements_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && placements_due.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
